// ===== rtl/core/gbl_pkg.sv =====
// shared types and constants of the backlight dimmer
package gbl_pkg;

	localparam int unsigned PERIOD_TICKS_DEF = 40000;
	localparam int unsigned LEVEL_W = 7;
	localparam logic [LEVEL_W-1:0] MAX_PCT = 7'd100;
	localparam int unsigned CUBE_W = 20;

	// floor(x / 1000000) as ((x >> 6) * CURVE_RECIP) >> 44, exact for x below 2^36
	localparam int unsigned SCALED_W = 36;
	localparam int unsigned MUL_A_W = 30;
	localparam int unsigned MUL_B_W = 31;
	localparam int unsigned CURVE_PRE_SHIFT = 6;
	localparam int unsigned CURVE_RECIP_SHIFT = 44;
	localparam logic [MUL_B_W-1:0] CURVE_RECIP = 31'd1125899907;

	localparam logic [2:0] FUNC_TICK = 3'd0;
	localparam logic [2:0] FUNC_INIT = 3'd1;
	localparam logic [2:0] FUNC_SET = 3'd2;
	localparam logic [2:0] FUNC_ADJUST = 3'd3;
	localparam logic [2:0] FUNC_STANDBY = 3'd4;

	localparam logic [1:0] REG_FEATURE = 2'd0;
	localparam logic [1:0] REG_NORMAL = 2'd1;
	localparam logic [1:0] REG_STANDBY = 2'd2;
	localparam logic [1:0] REG_MIN_ADJ = 2'd3;

	localparam logic [LEVEL_W-1:0] RST_USER_LEVEL = 7'd100;
	localparam logic [LEVEL_W-1:0] RST_NORMAL = 7'd80;
	localparam logic [LEVEL_W-1:0] RST_STANDBY = 7'd10;
	localparam logic [LEVEL_W-1:0] RST_MIN_ADJ = 7'd5;

	typedef enum logic [2:0] {
		CV_IDLE,
		CV_SQR,
		CV_CUBE,
		CV_SCALE,
		CV_DIV
	} curve_state_t;

	typedef enum logic {
		CT_IDLE,
		CT_CURVE
	} ctl_state_t;

	typedef struct packed {
		logic start;
		logic [LEVEL_W-1:0] level;
	} curve_req_t;

	typedef struct packed {
		logic done;
	} curve_rsp_t;

endpackage

// ===== rtl/core/gbl_curve.sv =====
// cubic curve unit: one shared multiplier for cube, period scale and reciprocal divide
module gbl_curve #(
	parameter int unsigned PERIOD_TICKS = gbl_pkg::PERIOD_TICKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  gbl_pkg::curve_req_t req,
	output gbl_pkg::curve_rsp_t rsp,
	output logic [$clog2(PERIOD_TICKS+1)-1:0] compare
);

	localparam int unsigned CW = $clog2(PERIOD_TICKS + 1);
	localparam int unsigned LW = gbl_pkg::CUBE_W;
	localparam int unsigned XW = gbl_pkg::SCALED_W;
	localparam int unsigned AW = gbl_pkg::MUL_A_W;
	localparam int unsigned BW = gbl_pkg::MUL_B_W;
	localparam int unsigned PW = AW + BW;
	localparam int unsigned SH = gbl_pkg::CURVE_PRE_SHIFT;
	localparam int unsigned QS = gbl_pkg::CURVE_RECIP_SHIFT;
	localparam logic [BW-1:0] PERIOD_C = BW'(PERIOD_TICKS);

	gbl_pkg::curve_state_t state_q, state_d;

	logic [gbl_pkg::LEVEL_W-1:0] lvl_q;
	logic [XW-1:0] acc_q;
	logic [CW-1:0] quo_q;
	logic done_q;

	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] prod;

	assign mul_a = (state_q == gbl_pkg::CV_DIV) ? acc_q[SH +: AW] : AW'(acc_q[LW-1:0]);
	assign mul_b = (state_q == gbl_pkg::CV_DIV) ? gbl_pkg::CURVE_RECIP :
		(state_q == gbl_pkg::CV_SCALE) ? PERIOD_C : BW'(lvl_q);
	assign prod = {{BW{1'b0}}, mul_a} * {{AW{1'b0}}, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbl_pkg::CV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gbl_pkg::CV_IDLE: begin
				if (req.start) begin
					state_d = gbl_pkg::CV_SQR;
				end
			end
			gbl_pkg::CV_SQR: state_d = gbl_pkg::CV_CUBE;
			gbl_pkg::CV_CUBE: state_d = gbl_pkg::CV_SCALE;
			gbl_pkg::CV_SCALE: state_d = gbl_pkg::CV_DIV;
			gbl_pkg::CV_DIV: state_d = gbl_pkg::CV_IDLE;
			default: state_d = gbl_pkg::CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == gbl_pkg::CV_DIV);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gbl_pkg::CV_IDLE: begin
				if (req.start) begin
					lvl_q <= req.level;
					acc_q <= XW'(req.level);
				end
			end
			gbl_pkg::CV_SQR, gbl_pkg::CV_CUBE, gbl_pkg::CV_SCALE: begin
				acc_q <= prod[XW-1:0];
			end
			gbl_pkg::CV_DIV: begin
				quo_q <= prod[QS +: CW];
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign compare = quo_q;

endmodule

// ===== rtl/core/gamma_backlight_pwm_controller_top.sv =====
// backlight dimmer top level: command decode, level state, pwm counter, register port
//
// usage: commands enter on the cmd channel (cmd_valid, cmd_stall, func, set_level,
// adjust_delta, standby_active); one result item per command leaves on the rsp
// channel (rsp_valid, rsp_stall, pwm_level, current_level, compare_value,
// forced_low, command_ignored). four registers sit on the apb port.
// a tick, a repeated init, an ignored standby or an unknown func is answered
// at the edge that accepts it; such items go back to back while rsp_stall is low.
// init, set, adjust and standby that apply a level run the cubic curve unit:
// square, cube, period scale and a reciprocal multiply for the divide by one
// million pass through one shared multiplier in turn, and the result enters
// the output register when the curve unit reports done, at any period;
// cmd_stall is high meanwhile.
// a result waits in the output register while rsp_stall is high; cmd_stall
// stays high until that register is free or draining.
// reset: level 100, full-scale compare, counter 0, not started, registers to
// their defaults, no result pending.
module gamma_backlight_pwm_controller_top #(
	parameter int unsigned PERIOD_TICKS = gbl_pkg::PERIOD_TICKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  logic [2:0] func,
	input  logic signed [7:0] set_level,
	input  logic signed [7:0] adjust_delta,
	input  logic standby_active,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic pwm_level,
	output logic [6:0] current_level,
	output logic [15:0] compare_value,
	output logic forced_low,
	output logic command_ignored
);

	localparam int unsigned CW = $clog2(PERIOD_TICKS + 1);
	localparam int unsigned CNW = $clog2(PERIOD_TICKS);
	localparam int unsigned SW = (CW > 16) ? CW : 17;
	localparam logic [CW-1:0] PERIOD_C = CW'(PERIOD_TICKS);
	localparam logic [CNW-1:0] CNT_LAST = CNW'(PERIOD_TICKS - 1);
	localparam int unsigned LW = gbl_pkg::LEVEL_W;

	function automatic logic [LW-1:0] clamp_top(input logic [LW-1:0] v);
		clamp_top = (v > gbl_pkg::MAX_PCT) ? gbl_pkg::MAX_PCT : v;
	endfunction

	function automatic logic [LW-1:0] clamp_set(input logic signed [7:0] v);
		logic [LW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > 8'sd100) begin
			r = gbl_pkg::MAX_PCT;
		end else begin
			r = v[LW-1:0];
		end
		clamp_set = r;
	endfunction

	function automatic logic [LW-1:0] adjust_level(input logic [LW-1:0] cur,
		input logic signed [7:0] delta, input logic [LW-1:0] lo);
		logic signed [9:0] v;
		v = $signed({3'b000, cur}) + $signed({{2{delta[7]}}, delta});
		if (v < $signed({3'b000, lo})) begin
			v = $signed({3'b000, lo});
		end
		if (v > 10'sd100) begin
			v = 10'sd100;
		end
		adjust_level = v[LW-1:0];
	endfunction

	// configuration
	logic feature_q;
	logic [LW-1:0] normal_q, standby_q, min_adj_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_q <= 1'b1;
			normal_q <= gbl_pkg::RST_NORMAL;
			standby_q <= gbl_pkg::RST_STANDBY;
			min_adj_q <= gbl_pkg::RST_MIN_ADJ;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				gbl_pkg::REG_FEATURE: feature_q <= pwdata[0];
				gbl_pkg::REG_NORMAL: normal_q <= pwdata[LW-1:0];
				gbl_pkg::REG_STANDBY: standby_q <= pwdata[LW-1:0];
				gbl_pkg::REG_MIN_ADJ: min_adj_q <= pwdata[LW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			gbl_pkg::REG_FEATURE: prdata = {31'd0, feature_q};
			gbl_pkg::REG_NORMAL: prdata = {25'd0, normal_q};
			gbl_pkg::REG_STANDBY: prdata = {25'd0, standby_q};
			gbl_pkg::REG_MIN_ADJ: prdata = {25'd0, min_adj_q};
			default: prdata = '0;
		endcase
	end

	// level and pwm state
	gbl_pkg::ctl_state_t state_q, state_d;
	logic [LW-1:0] user_q, saved_q, pct_q;
	logic [CW-1:0] cmp_q;
	logic [CNW-1:0] cnt_q;
	logic forced_q, started_q;
	logic rsp_valid_q;

	gbl_pkg::curve_req_t creq;
	gbl_pkg::curve_rsp_t crsp;
	logic [CW-1:0] curve_cmp;

	logic cmd_fire, rsp_fire;
	logic need_curve, ignored, save_level;
	logic [LW-1:0] pct_d;
	logic [CNW-1:0] cnt_d;
	logic imm_pin, done_pin, done_forced;
	logic [CW-1:0] done_cmp;

	assign cmd_stall = (state_q != gbl_pkg::CT_IDLE) | (rsp_valid_q & rsp_stall);
	assign cmd_fire = cmd_valid & ~cmd_stall;
	assign rsp_fire = rsp_valid_q & ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbl_pkg::CT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		need_curve = 1'b0;
		ignored = 1'b0;
		save_level = 1'b0;
		pct_d = saved_q;
		cnt_d = cnt_q;
		case (func)
			gbl_pkg::FUNC_TICK: begin
				if (started_q) begin
					cnt_d = (cnt_q == CNT_LAST) ? '0 : cnt_q + CNW'(1);
				end
			end
			gbl_pkg::FUNC_INIT: begin
				ignored = started_q;
				need_curve = ~started_q;
				pct_d = clamp_top(normal_q);
			end
			gbl_pkg::FUNC_SET: begin
				need_curve = 1'b1;
				pct_d = clamp_set(set_level);
			end
			gbl_pkg::FUNC_ADJUST: begin
				need_curve = 1'b1;
				pct_d = adjust_level(user_q, adjust_delta, min_adj_q);
			end
			gbl_pkg::FUNC_STANDBY: begin
				ignored = ~feature_q;
				need_curve = feature_q;
				save_level = feature_q & standby_active;
				pct_d = standby_active ? clamp_top(standby_q) : saved_q;
			end
			default: ignored = 1'b1;
		endcase
		case (state_q)
			gbl_pkg::CT_IDLE: begin
				if (cmd_fire && need_curve) begin
					state_d = gbl_pkg::CT_CURVE;
				end
			end
			gbl_pkg::CT_CURVE: begin
				if (crsp.done) begin
					state_d = gbl_pkg::CT_IDLE;
				end
			end
			default: state_d = gbl_pkg::CT_IDLE;
		endcase
	end

	assign creq.start = cmd_fire & need_curve;
	assign creq.level = pct_d;

	gbl_curve #(
		.PERIOD_TICKS(PERIOD_TICKS)
	) u_curve (
		.clk(clk),
		.arst_n(arst_n),
		.req(creq),
		.rsp(crsp),
		.compare(curve_cmp)
	);

	assign imm_pin = started_q & ~forced_q & (CW'(cnt_d) < cmp_q);
	assign done_forced = (curve_cmp == '0);
	assign done_cmp = done_forced ? cmp_q : curve_cmp;
	assign done_pin = started_q & ~done_forced & (CW'(cnt_q) < done_cmp);

	function automatic logic [15:0] sat16(input logic [CW-1:0] v);
		logic [SW-1:0] e;
		e = SW'(v);
		sat16 = (e > SW'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_q <= gbl_pkg::RST_USER_LEVEL;
			saved_q <= gbl_pkg::RST_USER_LEVEL;
			cmp_q <= PERIOD_C;
			cnt_q <= '0;
			forced_q <= 1'b0;
			started_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_fire) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd_fire) begin
				cnt_q <= cnt_d;
				if (save_level) begin
					saved_q <= user_q;
				end
				if ((func == gbl_pkg::FUNC_INIT) && !started_q) begin
					started_q <= 1'b1;
					cmp_q <= PERIOD_C;
				end
				if (!need_curve) begin
					rsp_valid_q <= 1'b1;
				end
			end
			if ((state_q == gbl_pkg::CT_CURVE) && crsp.done) begin
				user_q <= pct_q;
				cmp_q <= done_cmp;
				forced_q <= done_forced;
				rsp_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			pct_q <= pct_d;
			if (!need_curve) begin
				pwm_level <= imm_pin;
				current_level <= user_q;
				compare_value <= sat16(cmp_q);
				forced_low <= forced_q;
				command_ignored <= ignored;
			end else begin
				command_ignored <= 1'b0;
			end
		end
		if ((state_q == gbl_pkg::CT_CURVE) && crsp.done) begin
			pwm_level <= done_pin;
			current_level <= pct_q;
			compare_value <= sat16(done_cmp);
			forced_low <= done_forced;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the backlight dimmer: command channel, result channel, apb registers
module testbench;
	import gbl_pkg::*;

	localparam int unsigned PERIOD = PERIOD_TICKS_DEF;
	localparam int unsigned LATENCY_PAD = 40;
	localparam int unsigned ITEMS_PER_PHASE = 240;
	localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] FUNC_LAST = 3'd7;

	typedef struct {
		logic        pwm;
		logic [6:0]  level;
		logic [15:0] cmp;
		logic        forced;
		logic        ignored;
	} dimmer_rsp_t;

	class dimmer_model;
		logic        feat_en;
		logic [6:0]  norm_lvl;
		logic [6:0]  stby_lvl;
		logic [6:0]  min_adj;
		logic [6:0]  user_lvl;
		logic [6:0]  saved_lvl;
		int unsigned cmp_cnt;
		int unsigned counter;
		logic        forced;
		logic        running;
		dimmer_rsp_t expected_rsp[$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			feat_en = 1'b1;
			norm_lvl = RST_NORMAL;
			stby_lvl = RST_STANDBY;
			min_adj = RST_MIN_ADJ;
			user_lvl = RST_USER_LEVEL;
			saved_lvl = RST_USER_LEVEL;
			cmp_cnt = PERIOD;
			counter = 0;
			forced = 1'b0;
			running = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void note_mismatch(string what);
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: %s", what);
			end
		endfunction

		function int unsigned pending();
			return expected_rsp.size();
		endfunction

		function void apply_pct(int pct);
			longint unsigned lv;
			longint unsigned curve;
			if (pct < 0) pct = 0;
			if (pct > 100) pct = 100;
			user_lvl = 7'(pct);
			lv = pct;
			curve = (lv * lv * lv * PERIOD) / 64'd1000000;
			if (curve == 0) begin
				forced = 1'b1;
			end else begin
				cmp_cnt = 32'(curve);
				forced = 1'b0;
			end
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_FEATURE: feat_en = val[0];
				REG_NORMAL: norm_lvl = val[6:0];
				REG_STANDBY: stby_lvl = val[6:0];
				REG_MIN_ADJ: min_adj = val[6:0];
				default: ;
			endcase
		endfunction

		function void check_register(logic [1:0] idx, logic [31:0] got);
			logic [31:0] want;
			case (idx)
				REG_FEATURE: want = {31'd0, feat_en};
				REG_NORMAL: want = {25'd0, norm_lvl};
				REG_STANDBY: want = {25'd0, stby_lvl};
				default: want = {25'd0, min_adj};
			endcase
			if (got !== want) begin
				note_mismatch($sformatf("register %0d expected %0h got %0h",
					idx, want, got));
			end
		endfunction

		function void note_command(logic [2:0] f, logic signed [7:0] sl, logic signed [7:0] ad,
				logic sa);
			dimmer_rsp_t r;
			int v;
			logic ign;
			ign = 1'b0;
			case (f)
				FUNC_TICK: begin
					if (running) begin
						counter++;
						if (counter >= PERIOD) counter = 0;
					end
				end
				FUNC_INIT: begin
					if (running) begin
						ign = 1'b1;
					end else begin
						running = 1'b1;
						cmp_cnt = PERIOD;
						apply_pct(int'(norm_lvl));
					end
				end
				FUNC_SET: apply_pct(int'(sl));
				FUNC_ADJUST: begin
					v = int'(user_lvl) + int'(ad);
					if (v < int'(min_adj)) v = int'(min_adj);
					if (v > 100) v = 100;
					apply_pct(v);
				end
				FUNC_STANDBY: begin
					if (!feat_en) begin
						ign = 1'b1;
					end else if (sa) begin
						saved_lvl = user_lvl;
						apply_pct(int'(stby_lvl));
					end else begin
						apply_pct(int'(saved_lvl));
					end
				end
				default: ign = 1'b1;
			endcase
			r.pwm = running && !forced && (counter < cmp_cnt);
			r.level = user_lvl;
			r.cmp = (cmp_cnt > 32'hFFFF) ? 16'hFFFF : cmp_cnt[15:0];
			r.forced = forced;
			r.ignored = ign;
			expected_rsp.push_back(r);
		endfunction

		function void check_response(dimmer_rsp_t got);
			dimmer_rsp_t want;
			if (expected_rsp.size() == 0) begin
				note_mismatch("result item with nothing expected");
				return;
			end
			want = expected_rsp.pop_front();
			checked++;
			if (got.pwm !== want.pwm || got.level !== want.level || got.cmp !== want.cmp ||
					got.forced !== want.forced || got.ignored !== want.ignored) begin
				note_mismatch({
					$sformatf("expected pwm=%0d level=%0d cmp=%0d forced=%0d ign=%0d",
						want.pwm, want.level, want.cmp, want.forced, want.ignored),
					$sformatf(", got pwm=%0d level=%0d cmp=%0d forced=%0d ign=%0d",
						got.pwm, got.level, got.cmp, got.forced, got.ignored)});
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [2:0] func = '0;
	logic signed [7:0] set_level = '0;
	logic signed [7:0] adjust_delta = '0;
	logic standby_active = 1'b0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic pwm_level;
	logic [6:0] current_level;
	logic [15:0] compare_value;
	logic forced_low;
	logic command_ignored;

	dimmer_model model;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_left = 0;
	int unsigned n_cmds = 0;
	int unsigned n_ticks = 0;
	int unsigned n_settings = 0;

	gamma_backlight_pwm_controller_top #(
		.PERIOD_TICKS(PERIOD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.func(func),
		.set_level(set_level),
		.adjust_delta(adjust_delta),
		.standby_active(standby_active),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.pwm_level(pwm_level),
		.current_level(current_level),
		.compare_value(compare_value),
		.forced_low(forced_low),
		.command_ignored(command_ignored)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("gamma_backlight_pwm_controller_top test failed");
		$finish;
	end

	// result side: check accepted items, stall at random or for a requested hold-off
	initial begin
		dimmer_rsp_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				got.pwm = pwm_level;
				got.level = current_level;
				got.cmp = compare_value;
				got.forced = forced_low;
				got.ignored = command_ignored;
				model.check_response(got);
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic send_command(input logic [2:0] f, input logic signed [7:0] sl,
			input logic signed [7:0] ad, input logic sa);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		func <= f;
		set_level <= sl;
		adjust_delta <= ad;
		standby_active <= sa;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		model.note_command(f, sl, ad, sa);
		n_cmds++;
		if (f == FUNC_TICK) n_ticks++;
	endtask

	task automatic drain_responses(input int unsigned pad);
		cmd_valid <= 1'b0;
		while (model.pending() != 0) @(posedge clk);
		repeat (pad) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (wr) begin
			model.set_register(idx, val);
		end else begin
			model.check_register(idx, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_registers(input logic fe, input logic [6:0] nl, input logic [6:0] sl,
			input logic [6:0] ma);
		apb_access(1'b1, REG_FEATURE, {31'd0, fe});
		apb_access(1'b1, REG_NORMAL, {25'd0, nl});
		apb_access(1'b1, REG_STANDBY, {25'd0, sl});
		apb_access(1'b1, REG_MIN_ADJ, {25'd0, ma});
		apb_access(1'b0, REG_FEATURE, '0);
		apb_access(1'b0, REG_NORMAL, '0);
		apb_access(1'b0, REG_STANDBY, '0);
		apb_access(1'b0, REG_MIN_ADJ, '0);
		n_settings++;
	endtask

	task automatic send_random_command();
		logic [2:0] f;
		logic signed [7:0] sl;
		logic signed [7:0] ad;
		logic sa;
		int unsigned pick;
		sl = 8'($urandom);
		ad = 8'($urandom);
		sa = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 50) begin
			f = FUNC_TICK;
		end else if (pick < 62) begin
			f = FUNC_SET;
			case ($urandom_range(2))
				0: sl = 8'($urandom_range(100));
				1: sl = 8'($urandom_range(6));
				default: ;
			endcase
		end else if (pick < 76) begin
			f = FUNC_ADJUST;
			if ($urandom_range(3) != 0) ad = 8'($urandom_range(40)) - 8'd20;
		end else if (pick < 90) begin
			f = FUNC_STANDBY;
		end else if (pick < 95) begin
			f = FUNC_INIT;
		end else begin
			f = 3'($urandom_range(FUNC_LAST, FUNC_FIRST_UNUSED));
		end
		send_command(f, sl, ad, sa);
	endtask

	initial begin
		logic fe;
		logic [6:0] nl;
		logic [6:0] sl;
		logic [6:0] ma;
		model = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values read back, then a normal level above range so init clamps
		apb_access(1'b0, REG_FEATURE, '0);
		apb_access(1'b0, REG_NORMAL, '0);
		apb_access(1'b0, REG_STANDBY, '0);
		apb_access(1'b0, REG_MIN_ADJ, '0);
		apb_access(1'b1, REG_NORMAL, 32'd127);

		send_idle_pct = 32;
		recv_idle_pct = 56;

		// before init
		send_command(FUNC_TICK, 8'sd0, 8'sd0, 1'b0);
		send_command(FUNC_SET, 8'sd50, 8'sd0, 1'b0);
		send_command(FUNC_SET, -8'sd128, 8'sd0, 1'b0);
		send_command(FUNC_SET, 8'sd127, 8'sd0, 1'b0);
		send_command(FUNC_ADJUST, 8'sd0, -8'sd128, 1'b0);
		send_command(FUNC_ADJUST, 8'sd0, 8'sd127, 1'b0);
		send_command(FUNC_STANDBY, 8'sd0, 8'sd0, 1'b1);
		send_command(FUNC_STANDBY, 8'sd0, 8'sd0, 1'b0);
		send_command(FUNC_FIRST_UNUSED, -8'sd1, -8'sd1, 1'b1);
		send_command(FUNC_FIRST_UNUSED + 3'd1, 8'sd0, 8'sd0, 1'b0);
		send_command(FUNC_LAST, -8'sd1, -8'sd1, 1'b1);
		// init, then repeated init
		send_command(FUNC_INIT, 8'sd0, 8'sd0, 1'b0);
		send_command(FUNC_INIT, 8'sd0, 8'sd0, 1'b0);
		repeat (3) send_command(FUNC_TICK, 8'sd0, 8'sd0, 1'b0);
		send_command(FUNC_SET, 8'sd3, 8'sd0, 1'b0);
		repeat (2) send_command(FUNC_TICK, 8'sd0, 8'sd0, 1'b0);
		// zero curve keeps the old compare and forces the pin low
		send_command(FUNC_SET, 8'sd1, 8'sd0, 1'b0);
		send_command(FUNC_TICK, 8'sd0, 8'sd0, 1'b0);
		send_command(FUNC_SET, 8'sd0, 8'sd0, 1'b0);
		send_command(FUNC_ADJUST, 8'sd0, 8'sd1, 1'b0);
		send_command(FUNC_SET, 8'sd100, 8'sd0, 1'b0);
		drain_responses(LATENCY_PAD);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin fe = 1'b1; nl = 7'd0; sl = 7'd127; ma = 7'd0; end
				1: begin fe = 1'b0; nl = 7'd100; sl = 7'd0; ma = 7'd100; end
				2: begin fe = 1'b1; nl = 7'd127; sl = 7'd100; ma = 7'd127; end
				5: begin fe = 1'b1; nl = RST_NORMAL; sl = RST_STANDBY; ma = RST_MIN_ADJ; end
				default: begin
					fe = 1'($urandom);
					nl = 7'($urandom);
					sl = 7'($urandom);
					ma = 7'($urandom_range(40));
				end
			endcase
			if (p < 2) begin
				send_idle_pct = 32;
				recv_idle_pct = 56;
			end else if (p < 4) begin
				send_idle_pct = 56;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			program_registers(fe, nl, sl, ma);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == 0 && i == 100) hold_left = 400;
				if (p == 3 && i == 120) drain_responses(0);
				send_random_command();
			end
			drain_responses(LATENCY_PAD);
		end

		// tick runs after a set, payload fields random in the first run
		send_command(FUNC_SET, 8'sd50, 8'sd0, 1'b0);
		repeat (8) send_command(FUNC_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
		send_command(FUNC_SET, 8'sd3, 8'sd0, 1'b0);
		repeat (8) send_command(FUNC_TICK, 8'sd0, 8'sd0, 1'b0);
		drain_responses(LATENCY_PAD);

		$display("covered %0d commands (%0d ticks) over %0d register settings",
			n_cmds, n_ticks, n_settings);
		$display("%0d result items checked, %0d mismatches", model.checked, model.mismatches);
		if (model.mismatches == 0 && model.pending() == 0) begin
			$display("gamma_backlight_pwm_controller_top test passed");
		end else begin
			$display("gamma_backlight_pwm_controller_top test failed");
		end
		$finish;
	end

endmodule
